@@ hdl/gbn_pkg.sv @@
// gbn_pkg: shared constants, codes and the control/status structs of the
// Go-Back-N sender window. No dependencies; imported by every module of the block.

package gbn_pkg;

    // Window and segment sizing
    localparam int WINDOW_SIZE = 8;
    localparam int SEGMENT_BYTES = 247;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam logic [31:0] WINDOW_SIZE_W = 32'(WINDOW_SIZE);
    localparam logic [31:0] SEG_BYTES_W = 32'(SEGMENT_BYTES);
    localparam logic [7:0] SEG_BYTES_B = 8'(SEGMENT_BYTES);
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(WINDOW_SIZE - 1);

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CW_LIMIT = 1'd1;
    localparam logic [31:0] TOTAL_BYTES_RST = 32'd4;
    localparam logic [7:0] CW_LIMIT_RST = 8'd60;

    // Event kinds
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_REPLY = 2'd2;
    localparam logic [1:0] MODE_BROKEN = 2'd3;

    // Reply codes
    localparam logic [7:0] CODE_ACK = 8'd65;
    localparam logic [7:0] CODE_FIN = 8'd180;
    localparam logic [7:0] CODE_FINACK = 8'd255;
    localparam logic [7:0] REPLY_LEN_OK = 8'd1;

    // Result actions
    localparam logic [2:0] ACT_NEW = 3'd0;
    localparam logic [2:0] ACT_RESEND = 3'd1;
    localparam logic [2:0] ACT_FINACK = 3'd2;
    localparam logic [2:0] ACT_CLOSED = 3'd3;
    localparam logic [2:0] ACT_EXPIRED = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch_event;
        logic       clear_xfer;
        logic       clear_count;
        logic       set_base;
        logic       fill_queued;
        logic       load_resend;
        logic       cw_load;
        logic       cw_dec;
        logic       emit;
        logic [2:0] emit_action;
        logic       emit_last;
    } gbn_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] ev_mode;
        logic       reply_ok;
        logic       code_ack;
        logic       code_fin;
        logic       code_finack;
        logic       ack_in_range;
        logic       ack_final;
        logic       ack_empties;
        logic       finack_match;
        logic       all_queued;
        logic       win_empty;
        logic       new_last;
        logic       rs_last;
        logic       cw_le1;
        logic       limit_zero;
    } gbn_status_t;

endpackage

@@ hdl/gbn_ctrl.sv @@
// gbn_ctrl: protocol phase and sequencing state machine of the sender window.
// Depends on gbn_pkg; drives gbn_datapath through gbn_cmd_t, reads gbn_status_t.

module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  gbn_status_t status,
    output gbn_cmd_t    cmd
);

    // Protocol phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SENDING = 2'd1;
    localparam logic [1:0] PH_CLOSE_WAIT = 2'd2;
    localparam logic [1:0] PH_CLOSED = 2'd3;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_NEW = 3'd2;
    localparam logic [2:0] S_RESEND = 3'd3;
    localparam logic [2:0] S_FINACK = 3'd4;
    localparam logic [2:0] S_FINREPLY = 3'd5;
    localparam logic [2:0] S_EXPIRE = 3'd6;
    localparam logic [2:0] S_CLOSED = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;

    assign busy = (state_reg != S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_event = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.clear_count = 1'b1;
                state_next = S_IDLE;
                case (phase_reg)
                    PH_SENDING:
                    begin
                        if (status.ev_mode == MODE_TIMEOUT)
                        begin
                            cmd.load_resend = 1'b1;
                            if (!status.win_empty)
                                state_next = S_RESEND;
                        end
                        else if (status.reply_ok && status.code_fin)
                        begin
                            cmd.set_base = 1'b1;
                            cmd.fill_queued = 1'b1;
                            state_next = S_FINACK;
                        end
                        else if (status.reply_ok && status.code_ack && status.ack_in_range)
                        begin
                            cmd.set_base = 1'b1;
                            if (status.ack_final)
                                state_next = S_FINACK;
                            else if (status.ack_empties)
                                state_next = S_NEW;
                        end
                    end
                    PH_CLOSE_WAIT:
                    begin
                        if (status.ev_mode == MODE_TIMEOUT)
                        begin
                            cmd.cw_dec = 1'b1;
                            if (status.cw_le1)
                                state_next = S_EXPIRE;
                        end
                        else if (status.reply_ok && status.code_finack && status.finack_match)
                            state_next = S_CLOSED;
                        else if (status.reply_ok && status.code_fin)
                            state_next = S_FINREPLY;
                    end
                    default:
                    begin
                        // idle or closed: only a start does anything
                        if (status.ev_mode == MODE_START)
                        begin
                            phase_next = PH_SENDING;
                            cmd.clear_xfer = 1'b1;
                            state_next = S_NEW;
                        end
                    end
                endcase
            end
            S_NEW:
            begin
                // nothing left to queue on entry: data phase is over
                if (status.all_queued)
                    state_next = S_FINACK;
                else
                begin
                    cmd.emit = 1'b1;
                    cmd.emit_action = ACT_NEW;
                    if (status.new_last)
                        state_next = S_IDLE;
                end
            end
            S_RESEND:
            begin
                cmd.emit = 1'b1;
                cmd.emit_action = ACT_RESEND;
                if (status.rs_last)
                    state_next = S_IDLE;
            end
            S_FINACK:
            begin
                phase_next = PH_CLOSE_WAIT;
                cmd.cw_load = 1'b1;
                cmd.emit = 1'b1;
                cmd.emit_action = ACT_FINACK;
                cmd.emit_last = !status.limit_zero;
                state_next = status.limit_zero ? S_EXPIRE : S_IDLE;
            end
            S_FINREPLY:
            begin
                cmd.emit = 1'b1;
                cmd.emit_action = ACT_FINACK;
                cmd.emit_last = 1'b1;
                state_next = S_IDLE;
            end
            S_EXPIRE:
            begin
                phase_next = PH_CLOSED;
                cmd.emit = 1'b1;
                cmd.emit_action = ACT_EXPIRED;
                cmd.emit_last = 1'b1;
                state_next = S_IDLE;
            end
            S_CLOSED:
            begin
                phase_next = PH_CLOSED;
                cmd.emit = 1'b1;
                cmd.emit_action = ACT_CLOSED;
                cmd.emit_last = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

@@ hdl/gbn_datapath.sv @@
// gbn_datapath: window pointers, byte counters, close-wait timer, configuration
// registers and the result register. Depends on gbn_pkg; driven by gbn_ctrl.

module gbn_datapath
    import gbn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gbn_cmd_t             cmd,
    output gbn_status_t          status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [1:0]           mode,
    input  logic [31:0]          reply_seq,
    input  logic [7:0]           reply_code,
    input  logic [7:0]           reply_length,
    output logic                 result_strobe,
    output logic [2:0]           action,
    output logic [31:0]          seq,
    output logic [31:0]          byte_offset,
    output logic [7:0]           seg_length,
    output logic                 last
);

    // Configuration
    logic [31:0] total_bytes_reg;
    logic [7:0]  cw_limit_reg;

    // Latched event
    logic [1:0]  mode_reg;
    logic [31:0] rseq_reg;
    logic [7:0]  code_reg;
    logic [7:0]  rlen_reg;

    // Transfer state
    logic [31:0] base_reg, base_next;
    logic [31:0] next_seq_reg, next_seq_next;
    logic [31:0] queued_reg, queued_next;
    logic [7:0]  cw_left_reg, cw_left_next;
    logic [CNT_W-1:0] new_count_reg, new_count_next;

    // Resend walker
    logic [31:0] rs_seq_reg, rs_seq_next;
    logic [31:0] rs_off_reg, rs_off_next;
    logic [CNT_W-1:0] rs_left_reg, rs_left_next;

    // Result register
    logic        strobe_reg;
    logic [2:0]  action_reg;
    logic [31:0] seq_reg;
    logic [31:0] offset_reg;
    logic [7:0]  len_reg;
    logic        last_reg;

    logic [31:0] rseq_plus1;
    logic [31:0] win_diff;
    logic [CNT_W-1:0] win_count;
    logic [31:0] new_rem;
    logic [7:0]  new_len;
    logic        new_last;
    logic [31:0] rs_rem;
    logic [7:0]  rs_len;
    logic        all_queued;
    logic        emit_new;
    logic        emit_resend;
    logic        res_last;

    // Comparisons against the window
    assign rseq_plus1 = rseq_reg + 32'd1;
    assign win_diff = next_seq_reg - base_reg;
    assign win_count = (win_diff > WINDOW_SIZE_W) ? CNT_W'(WINDOW_SIZE) : win_diff[CNT_W-1:0];
    assign all_queued = (queued_reg >= total_bytes_reg);

    // Next new segment
    assign new_rem = total_bytes_reg - queued_reg;
    assign new_len = (new_rem < SEG_BYTES_W) ? new_rem[7:0] : SEG_BYTES_B;
    assign new_last = (new_rem <= SEG_BYTES_W) || (new_count_reg == LAST_SLOT);

    // Resent segment length, clipped to what has been queued
    assign rs_rem = queued_reg - rs_off_reg;
    always_comb
    begin
        if (rs_off_reg >= queued_reg)
            rs_len = 8'd0;
        else if (rs_rem < SEG_BYTES_W)
            rs_len = rs_rem[7:0];
        else
            rs_len = SEG_BYTES_B;
    end

    // Status to the controller
    always_comb
    begin
        status.ev_mode = mode_reg;
        status.reply_ok = (mode_reg == MODE_REPLY) && (rlen_reg == REPLY_LEN_OK);
        status.code_ack = (code_reg == CODE_ACK);
        status.code_fin = (code_reg == CODE_FIN);
        status.code_finack = (code_reg == CODE_FINACK);
        status.ack_in_range = ((rseq_reg - base_reg) < win_diff);
        status.ack_final = all_queued && (next_seq_reg == rseq_plus1);
        status.ack_empties = (next_seq_reg == rseq_plus1);
        status.finack_match = (rseq_reg == next_seq_reg);
        status.all_queued = all_queued;
        status.win_empty = (win_diff == 32'd0);
        status.new_last = new_last;
        status.rs_last = (rs_left_reg == CNT_W'(1));
        status.cw_le1 = (cw_left_reg <= 8'd1);
        status.limit_zero = (cw_limit_reg == 8'd0);
    end

    assign emit_new = cmd.emit && (cmd.emit_action == ACT_NEW);
    assign emit_resend = cmd.emit && (cmd.emit_action == ACT_RESEND);

    // Transfer state updates
    always_comb
    begin
        base_next = base_reg;
        next_seq_next = next_seq_reg;
        queued_next = queued_reg;
        new_count_next = new_count_reg;
        cw_left_next = cw_left_reg;
        rs_seq_next = rs_seq_reg;
        rs_off_next = rs_off_reg;
        rs_left_next = rs_left_reg;

        if (cmd.clear_xfer)
        begin
            base_next = 32'd0;
            next_seq_next = 32'd0;
            queued_next = 32'd0;
        end
        if (cmd.set_base)
            base_next = rseq_plus1;
        if (cmd.fill_queued)
            queued_next = total_bytes_reg;
        if (cmd.clear_count)
            new_count_next = '0;
        if (emit_new)
        begin
            next_seq_next = next_seq_reg + 32'd1;
            queued_next = queued_reg + {24'd0, new_len};
            new_count_next = new_count_reg + CNT_W'(1);
        end

        // resend walker: offset steps by one segment per result
        if (cmd.load_resend)
        begin
            rs_seq_next = base_reg;
            rs_off_next = base_reg * SEG_BYTES_W;
            rs_left_next = win_count;
        end
        else if (emit_resend)
        begin
            rs_seq_next = rs_seq_reg + 32'd1;
            rs_off_next = rs_off_reg + SEG_BYTES_W;
            rs_left_next = rs_left_reg - CNT_W'(1);
        end

        // close-wait timer
        if (cmd.cw_load)
            cw_left_next = cw_limit_reg;
        else if (cmd.cw_dec && (cw_left_reg != 8'd0))
            cw_left_next = cw_left_reg - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'd0;
            next_seq_reg <= 32'd0;
            queued_reg <= 32'd0;
            cw_left_reg <= 8'd0;
            new_count_reg <= '0;
            total_bytes_reg <= TOTAL_BYTES_RST;
            cw_limit_reg <= CW_LIMIT_RST;
            strobe_reg <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            next_seq_reg <= next_seq_next;
            queued_reg <= queued_next;
            cw_left_reg <= cw_left_next;
            new_count_reg <= new_count_next;
            strobe_reg <= cmd.emit;
            if (cfg_we && (cfg_index == CFG_TOTAL_BYTES))
                total_bytes_reg <= cfg_data;
            if (cfg_we && (cfg_index == CFG_CW_LIMIT))
                cw_limit_reg <= cfg_data[7:0];
        end
    end

    // Event latch and resend walker (payload)
    always_ff @(posedge clk)
    begin
        if (cmd.latch_event)
        begin
            mode_reg <= mode;
            rseq_reg <= reply_seq;
            code_reg <= reply_code;
            rlen_reg <= reply_length;
        end
        rs_seq_reg <= rs_seq_next;
        rs_off_reg <= rs_off_next;
        rs_left_reg <= rs_left_next;
    end

    // Result register
    always_comb
    begin
        case (cmd.emit_action)
            ACT_NEW:    res_last = new_last;
            ACT_RESEND: res_last = (rs_left_reg == CNT_W'(1));
            default:    res_last = cmd.emit_last;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            action_reg <= cmd.emit_action;
            last_reg <= res_last;
            case (cmd.emit_action)
                ACT_NEW:
                begin
                    seq_reg <= next_seq_reg;
                    offset_reg <= queued_reg;
                    len_reg <= new_len;
                end
                ACT_RESEND:
                begin
                    seq_reg <= rs_seq_reg;
                    offset_reg <= rs_off_reg;
                    len_reg <= rs_len;
                end
                ACT_FINACK:
                begin
                    seq_reg <= next_seq_reg;
                    offset_reg <= 32'd0;
                    len_reg <= 8'd1;
                end
                default:
                begin
                    seq_reg <= 32'd0;
                    offset_reg <= 32'd0;
                    len_reg <= 8'd0;
                end
            endcase
        end
    end

    assign result_strobe = strobe_reg;
    assign action = action_reg;
    assign seq = seq_reg;
    assign byte_offset = offset_reg;
    assign seg_length = len_reg;
    assign last = last_reg;

endmodule

@@ hdl/go_back_n_sender_window.sv @@
// go_back_n_sender_window: top level of the Go-Back-N sender window.
// Depends on gbn_pkg, gbn_ctrl and gbn_datapath.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------------
//  event in  | start high, busy low      | mode, reply_seq, reply_code, reply_length
//  result out| result_strobe, one cycle  | action, seq, byte_offset, seg_length, last
//  config    | cfg_we                    | cfg_index, cfg_data
//
// After acceptance an event passes the decode state, then one result is emitted per
// cycle; busy falls as the last result is strobed. A start with nothing to send
// passes the new-segment state without a result before its FIN-ACK. A window resend
// or a burst of new segments gives up to WINDOW_SIZE results from the result register.
// Reset is asynchronous, active low, and takes effect at once.
// Results cannot be held off: each is valid for exactly its strobe cycle.

module go_back_n_sender_window
    import gbn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic [31:0]          reply_seq,
    input  logic [7:0]           reply_code,
    input  logic [7:0]           reply_length,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 result_strobe,
    output logic [2:0]           action,
    output logic [31:0]          seq,
    output logic [31:0]          byte_offset,
    output logic [7:0]           seg_length,
    output logic                 last
);

    gbn_cmd_t    cmd;
    gbn_status_t status;

    // Sequencer
    gbn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Pointers, counters and result register
    gbn_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .reply_seq     (reply_seq),
        .reply_code    (reply_code),
        .reply_length  (reply_length),
        .result_strobe (result_strobe),
        .action        (action),
        .seq           (seq),
        .byte_offset   (byte_offset),
        .seg_length    (seg_length),
        .last          (last)
    );

endmodule

@@ tb/tb_go_back_n_sender_window.sv @@
// tb_go_back_n_sender_window: self-checking testbench for the Go-Back-N sender window.
// Depends on gbn_pkg and go_back_n_sender_window; predicts every send command
// internally and checks each strobed result in order.

module tb_go_back_n_sender_window;
    import gbn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Sender phase as tracked by the predictor
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_SENDING    = 2'd1,
        PH_CLOSE_WAIT = 2'd2,
        PH_CLOSED     = 2'd3
    } sender_phase_e;

    typedef struct packed {
        sender_phase_e ph;
        logic [31:0]   base;
        logic [31:0]   nxt;
        logic [31:0]   queued;
        logic [7:0]    cw_left;
    } sender_state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] seq;
        logic [31:0] byte_offset;
        logic [7:0]  seg_length;
        logic        last;
    } send_cmd_t;

    // Block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           mode = MODE_START;
    logic [31:0]          reply_seq = 32'd0;
    logic [7:0]           reply_code = 8'd0;
    logic [7:0]           reply_length = 8'd0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_TOTAL_BYTES;
    logic [31:0]          cfg_data = 32'd0;
    logic                 result_strobe;
    logic [2:0]           action;
    logic [31:0]          seq;
    logic [31:0]          byte_offset;
    logic [7:0]           seg_length;
    logic                 last;

    // Predictor state and configuration copy
    sender_state_t st;
    logic [31:0]   total_bytes_cfg;
    logic [7:0]    cw_limit_cfg;
    send_cmd_t     cmd_scratch [WINDOW_SIZE + 2];
    int            n_scratch;

    // Expected results, kept as a ring
    send_cmd_t     expected_cmds [256];
    logic [7:0]    exp_wr_ptr = 8'd0;
    logic [7:0]    exp_rd_ptr = 8'd0;

    int errors = 0;
    bit idling_on = 1'b1;

    go_back_n_sender_window dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .reply_seq     (reply_seq),
        .reply_code    (reply_code),
        .reply_length  (reply_length),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .action        (action),
        .seq           (seq),
        .byte_offset   (byte_offset),
        .seg_length    (seg_length),
        .last          (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #1_000_000;
        $display("go_back_n_sender_window test failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic bit all_queued();
        return st.queued >= total_bytes_cfg;
    endfunction

    // Results predicted but not yet seen
    function automatic int pending_results();
        return int'(8'(exp_wr_ptr - exp_rd_ptr));
    endfunction

    task automatic push_cmd(logic [2:0] act, logic [31:0] s, logic [31:0] off, logic [7:0] len);
        cmd_scratch[n_scratch] = '{act, s, off, len, 1'b0};
        n_scratch++;
    endtask

    // Fill an empty window with fresh segments
    task automatic issue_new_segments();
        int n;
        logic [31:0] rem;
        logic [31:0] len;
        n = 0;
        while (!all_queued() && n < WINDOW_SIZE)
        begin
            rem = total_bytes_cfg - st.queued;
            len = (rem < SEG_BYTES_W) ? rem : SEG_BYTES_W;
            push_cmd(ACT_NEW, st.nxt, st.queued, len[7:0]);
            st.queued = st.queued + len;
            st.nxt = st.nxt + 32'd1;
            n++;
        end
    endtask

    task automatic enter_close_wait();
        st.ph = PH_CLOSE_WAIT;
        st.cw_left = cw_limit_cfg;
        push_cmd(ACT_FINACK, st.nxt, 32'd0, 8'd1);
        if (st.cw_left == 8'd0)
        begin
            st.ph = PH_CLOSED;
            push_cmd(ACT_EXPIRED, 32'd0, 32'd0, 8'd0);
        end
    endtask

    task automatic finish_if_drained();
        if (all_queued() && st.nxt == st.base)
            enter_close_wait();
    endtask

    // Work out the send commands one accepted event causes
    task automatic predict_event(logic [1:0] md, logic [31:0] rs, logic [7:0] rc,
                                 logic [7:0] rl);
        logic        ok;
        logic [31:0] span;
        logic [31:0] count;
        logic [31:0] s;
        logic [31:0] off;
        logic [31:0] rem;
        logic [31:0] len;
        send_cmd_t   c;
        int          i;
        n_scratch = 0;
        ok = (md == MODE_REPLY) && (rl == REPLY_LEN_OK);
        span = st.nxt - st.base;
        case (st.ph)
            PH_IDLE, PH_CLOSED:
            begin
                if (md == MODE_START)
                begin
                    st.ph = PH_SENDING;
                    st.base = 32'd0;
                    st.nxt = 32'd0;
                    st.queued = 32'd0;
                    issue_new_segments();
                    finish_if_drained();
                end
            end
            PH_SENDING:
            begin
                if (md == MODE_TIMEOUT)
                begin
                    // resend the whole window, lengths clipped to what is queued
                    count = (span > WINDOW_SIZE_W) ? WINDOW_SIZE_W : span;
                    for (i = 0; i < count; i++)
                    begin
                        s = st.base + i;
                        off = s * SEG_BYTES_W;
                        len = 32'd0;
                        if (off < st.queued)
                        begin
                            rem = st.queued - off;
                            len = (rem < SEG_BYTES_W) ? rem : SEG_BYTES_W;
                        end
                        push_cmd(ACT_RESEND, s, off, len[7:0]);
                    end
                end
                else if (ok && rc == CODE_FIN)
                begin
                    st.queued = total_bytes_cfg;
                    st.base = rs + 32'd1;
                    enter_close_wait();
                end
                else if (ok && rc == CODE_ACK && (rs - st.base) < span)
                begin
                    if (all_queued() && st.nxt == rs + 32'd1)
                    begin
                        st.base = rs + 32'd1;
                        enter_close_wait();
                    end
                    else
                    begin
                        st.base = rs + 32'd1;
                        if (st.base == st.nxt)
                        begin
                            issue_new_segments();
                            finish_if_drained();
                        end
                    end
                end
            end
            default:
            begin
                // close wait
                if (md == MODE_TIMEOUT)
                begin
                    if (st.cw_left != 8'd0)
                        st.cw_left = st.cw_left - 8'd1;
                    if (st.cw_left == 8'd0)
                    begin
                        st.ph = PH_CLOSED;
                        push_cmd(ACT_EXPIRED, 32'd0, 32'd0, 8'd0);
                    end
                end
                else if (ok && rc == CODE_FINACK && rs == st.nxt)
                begin
                    st.ph = PH_CLOSED;
                    push_cmd(ACT_CLOSED, 32'd0, 32'd0, 8'd0);
                end
                else if (ok && rc == CODE_FIN)
                begin
                    push_cmd(ACT_FINACK, st.nxt, 32'd0, 8'd1);
                end
            end
        endcase
        for (i = 0; i < n_scratch; i++)
        begin
            c = cmd_scratch[i];
            c.last = (i == n_scratch - 1);
            expected_cmds[exp_wr_ptr] = c;
            exp_wr_ptr = exp_wr_ptr + 8'd1;
        end
    endtask

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        send_cmd_t want;
        if (rst_n === 1'b1 && result_strobe === 1'b1)
        begin
            if (pending_results() == 0)
            begin
                $error("result_strobe: expected no transaction, got action %0d", action);
                errors++;
            end
            else
            begin
                want = expected_cmds[exp_rd_ptr];
                exp_rd_ptr = exp_rd_ptr + 8'd1;
                compare_field("action", 32'(want.action), 32'(action));
                compare_field("seq", want.seq, seq);
                compare_field("byte_offset", want.byte_offset, byte_offset);
                compare_field("seg_length", 32'(want.seg_length), 32'(seg_length));
                compare_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------
    // One event transaction, with an optional idle burst in front
    task automatic send_event(logic [1:0] md, logic [31:0] rs, logic [7:0] rc,
                              logic [7:0] rl);
        if (idling_on && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        start        <= 1'b1;
        mode         <= md;
        reply_seq    <= rs;
        reply_code   <= rc;
        reply_length <= rl;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_event(md, rs, rc, rl);
    endtask

    task automatic send_noise();
        send_event(2'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 247)));
    endtask

    // Wait until every expected result is in and the block is idle
    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_results() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic program_config(logic [31:0] total, logic [7:0] limit);
        wait_quiet();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TOTAL_BYTES;
        cfg_data  <= total;
        @(posedge clk);
        total_bytes_cfg = total;
        cfg_index <= CFG_CW_LIMIT;
        cfg_data  <= {24'd0, limit};
        @(posedge clk);
        cw_limit_cfg = limit;
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Single short segment at reset settings, full close handshake
    task automatic test_basic_transfer();
        send_event(MODE_TIMEOUT, 32'd0, 8'd0, 8'd0);          // ignored when idle
        send_event(MODE_START, 32'd0, 8'd0, 8'd0);
        send_event(MODE_START, 32'd5, 8'd0, 8'd0);            // start while sending
        send_event(MODE_BROKEN, 32'd0, CODE_ACK, REPLY_LEN_OK);
        send_event(MODE_REPLY, 32'd0, CODE_ACK, 8'd0);        // bad reply length
        send_event(MODE_REPLY, 32'd0, CODE_ACK, REPLY_LEN_OK); // final ACK
        send_event(MODE_REPLY, 32'd0, CODE_FINACK, REPLY_LEN_OK); // wrong seq
        send_event(MODE_REPLY, 32'd0, CODE_FIN, REPLY_LEN_OK);
        send_event(MODE_REPLY, 32'd1, CODE_FINACK, REPLY_LEN_OK);
        send_event(MODE_REPLY, 32'd1, CODE_ACK, 8'd247);      // ignored when closed
    endtask

    // Window sliding, rejection, resend and FIN over a huge message
    task automatic test_window_sliding();
        program_config(32'hFFFF_FFFF, 8'd1);
        send_event(MODE_START, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        send_event(MODE_REPLY, 32'd3, CODE_ACK, REPLY_LEN_OK);
        send_event(MODE_REPLY, 32'hFFFF_FFFF, CODE_ACK, REPLY_LEN_OK); // out of window
        send_event(MODE_TIMEOUT, 32'd0, 8'd0, 8'd0);
        send_event(MODE_REPLY, 32'd7, CODE_ACK, REPLY_LEN_OK);         // window empties
        send_event(MODE_REPLY, 32'hFFFF_FFFF, CODE_FIN, REPLY_LEN_OK);
        send_event(MODE_TIMEOUT, 32'd0, 8'd0, 8'd0);                   // expiry
    endtask

    // Empty message, zero close-wait limit, total lowered mid-transfer
    task automatic test_config_corners();
        program_config(32'd0, 8'd0);
        send_event(MODE_START, 32'd0, 8'd0, 8'd0);
        program_config(32'd600, 8'd2);
        send_event(MODE_START, 32'd0, 8'd0, 8'd0);
        program_config(32'd300, 8'd2);
        send_event(MODE_TIMEOUT, 32'd0, 8'd0, 8'd0);
        send_event(MODE_REPLY, 32'd1, CODE_ACK, REPLY_LEN_OK);
        send_event(MODE_REPLY, 32'd2, CODE_ACK, REPLY_LEN_OK);
        send_event(MODE_REPLY, 32'd3, 8'd0, REPLY_LEN_OK);            // unknown code
        send_event(MODE_TIMEOUT, 32'd0, 8'd0, 8'd0);
        send_event(MODE_TIMEOUT, 32'd0, 8'd0, 8'd0);
    endtask

    // One random event, mostly well formed for the current phase
    task automatic random_event();
        logic [31:0]   span;
        logic [31:0]   rs;
        int            r;
        span = st.nxt - st.base;
        r = $urandom_range(0, 99);
        case (st.ph)
            PH_SENDING:
            begin
                if (r < 50)
                begin
                    // in-window ACK, often for the newest segment
                    if (span == 32'd0)
                        rs = st.base;
                    else if ($urandom_range(0, 1) == 0)
                        rs = st.nxt - 32'd1;
                    else
                        rs = st.base + $urandom_range(0, span - 1);
                    send_event(MODE_REPLY, rs, CODE_ACK, REPLY_LEN_OK);
                end
                else if (r < 65)
                    send_event(MODE_TIMEOUT, $urandom, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 247)));
                else if (r < 70)
                    send_event(MODE_REPLY, $urandom, CODE_FIN, REPLY_LEN_OK);
                else if (r < 80)
                    send_event(MODE_REPLY, $urandom, CODE_ACK, REPLY_LEN_OK);
                else
                    send_noise();
            end
            PH_CLOSE_WAIT:
            begin
                if (r < 30)
                    send_event(MODE_REPLY, $urandom, CODE_FIN, REPLY_LEN_OK);
                else if (r < 55)
                    send_event(MODE_REPLY, st.nxt, CODE_FINACK, REPLY_LEN_OK);
                else if (r < 65)
                    send_event(MODE_REPLY, $urandom, CODE_FINACK, REPLY_LEN_OK);
                else if (r < 85)
                    send_event(MODE_TIMEOUT, $urandom, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 247)));
                else
                    send_noise();
            end
            default:
            begin
                if (r < 85)
                    send_event(MODE_START, $urandom, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 247)));
                else
                    send_noise();
            end
        endcase
    endtask

    // Random traffic over several register settings, no idling in the last one
    task automatic test_random_traffic();
        int p;
        int k;
        for (p = 0; p < 5; p++)
        begin
            case (p)
                0: program_config(32'($urandom_range(4, 3000)), 8'd255);
                1: program_config(32'hFFFF_FFFF, 8'($urandom_range(1, 4)));
                2: program_config(32'd4, 8'd1);
                3: program_config(32'($urandom_range(4, 1200)), 8'($urandom_range(1, 255)));
                default: program_config(32'($urandom_range(4, 2500)), 8'($urandom_range(1, 6)));
            endcase
            if (p == 4)
                idling_on = 1'b0;
            for (k = 0; k < 17; k++)
                random_event();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        st = '{PH_IDLE, 32'd0, 32'd0, 32'd0, 8'd0};
        total_bytes_cfg = TOTAL_BYTES_RST;
        cw_limit_cfg = CW_LIMIT_RST;
        n_scratch = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_transfer();
        test_window_sliding();
        test_config_corners();
        test_random_traffic();

        wait_quiet();
        repeat (12) @(posedge clk);
        if (errors == 0)
            $display("go_back_n_sender_window test passed");
        else
            $display("go_back_n_sender_window test failed");
        $finish;
    end

endmodule
